### src/wcam_pkg.sv
// Shared types and register codes for the windowed charge alert monitor.
// No dependencies; the other files that use it refer to this package by scoped names.
`default_nettype none

package wcam_pkg;

    // One monitoring tick as it travels on tdata and as it sits in the ring memory.
    // The first field is the highest one.
    typedef struct packed {
        logic [15:0] temp_b;   // signed hundredths of a degree
        logic [15:0] temp_a;   // signed hundredths of a degree
        logic [15:0] amp;      // milliamps
        logic [15:0] volt;     // millivolts
    } t_sample;

    localparam int SAMPLE_W = $bits(t_sample);

    // One result word; flag_overvoltage sits in bit 0.
    typedef struct packed {
        logic window_ready;
        logic halted;
        logic alert_now;
        logic flag_full;
        logic flag_overtemp;
        logic flag_overcurrent;
        logic flag_overvoltage;
    } t_result;

    localparam int RESULT_W = $bits(t_result);
    localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OV_LIMIT   = 3'd0,
        CFG_OC_LIMIT   = 3'd1,
        CFG_OT_LIMIT   = 3'd2,
        CFG_FULL_MIN_V = 3'd3,
        CFG_FULL_MAX_I = 3'd4,
        CFG_FULL_CHECK = 3'd5
    } t_cfg_idx;

    localparam logic [15:0] FULL_CHECK_RESET = 16'd10;
    localparam logic [15:0] RUN_COUNT_MAX    = 16'hFFFF;

    // Full-charge qualification settings, used as they are written
    typedef struct packed {
        logic [15:0] min_volt;
        logic [15:0] max_amp;
        logic [15:0] check_limit;
    } t_full_cfg;

endpackage

`default_nettype wire

### src/wcam_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module wcam_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### src/wcam_cfg.sv
// Configuration registers; average limits are kept as sum thresholds.
// Depends on wcam_pkg.
`default_nettype none

module wcam_cfg #(
    parameter int WINDOW = 16,
    parameter int SUM_W  = 20
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_wr,
    input  wire logic [wcam_pkg::CFG_IDX_W-1:0] i_idx,
    input  wire logic [15:0]                   i_data,
    output logic      [SUM_W-1:0]              o_thr_volt,
    output logic      [SUM_W-1:0]              o_thr_amp,
    output logic signed [SUM_W-1:0]            o_thr_temp,
    output wcam_pkg::t_full_cfg                o_full
);

    localparam int SW1 = SUM_W + 1;
    // floor(sum / WINDOW) > L  is the same as  sum > L * WINDOW + WINDOW - 1
    localparam logic [SUM_W-1:0] THR_RESET = SUM_W'(WINDOW - 1);

    logic [SUM_W-1:0]        n_thr_u;
    logic signed [SUM_W-1:0] n_thr_s;

    assign n_thr_u = SUM_W'(SW1'(i_data) * SW1'(WINDOW) + SW1'(WINDOW - 1));
    assign n_thr_s = SUM_W'(SW1'(signed'(i_data)) * SW1'(WINDOW) + SW1'(WINDOW - 1));

    // Register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_thr_volt         <= THR_RESET;
            o_thr_amp          <= THR_RESET;
            o_thr_temp         <= signed'(THR_RESET);
            o_full.min_volt    <= '0;
            o_full.max_amp     <= '0;
            o_full.check_limit <= wcam_pkg::FULL_CHECK_RESET;
        end else if (i_wr) begin
            unique case (i_idx)
                wcam_pkg::CFG_OV_LIMIT:   o_thr_volt         <= n_thr_u;
                wcam_pkg::CFG_OC_LIMIT:   o_thr_amp          <= n_thr_u;
                wcam_pkg::CFG_OT_LIMIT:   o_thr_temp         <= n_thr_s;
                wcam_pkg::CFG_FULL_MIN_V: o_full.min_volt    <= i_data;
                wcam_pkg::CFG_FULL_MAX_I: o_full.max_amp     <= i_data;
                wcam_pkg::CFG_FULL_CHECK: o_full.check_limit <= i_data;
                default: ;  // unused index, write dropped
            endcase
        end
    end

endmodule

`default_nettype wire

### src/wcam_eval.sv
// Running sums, fill tracking, limit checks, full-charge run count and alert state.
// Depends on wcam_pkg.
`default_nettype none

module wcam_eval #(
    parameter int WINDOW = 16,
    parameter int SUM_W  = 20,
    parameter int AW     = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_go,       // item leaves the update stage
    input  wire wcam_pkg::t_sample    i_sample,
    input  wire logic                 i_chg,
    input  wire wcam_pkg::t_sample    i_old,      // ring entry being replaced
    input  wire logic [AW-1:0]        i_pos,
    input  wire logic [SUM_W-1:0]     i_thr_volt,
    input  wire logic [SUM_W-1:0]     i_thr_amp,
    input  wire logic signed [SUM_W-1:0] i_thr_temp,
    input  wire wcam_pkg::t_full_cfg  i_full,
    output logic                      o_wr,       // write new sample to the ring
    output wcam_pkg::t_result         o_result
);

    logic [SUM_W-1:0]        r_vsum, r_asum;
    logic signed [SUM_W-1:0] r_tasum, r_tbsum;
    logic                    r_filled;
    logic [15:0]             r_run_cnt;
    logic [3:0]              r_bits;
    logic                    r_alerted;

    logic [SUM_W-1:0]        n_vsum, n_asum;
    logic signed [SUM_W-1:0] n_tasum, n_tbsum;
    logic                    n_filled;
    logic [15:0]             n_run_cnt;
    logic [3:0]              n_bits;
    wcam_pkg::t_sample       sub;
    logic [15:0]             cnt_inc;
    logic                    qual, v_hi, a_hi, t_hi, full_hit, entered;

    assign o_wr = i_go && !r_alerted;

    // Old entries only leave the sums once the ring has filled
    assign sub = r_filled ? i_old : '0;

    assign n_vsum  = r_vsum - SUM_W'(sub.volt) + SUM_W'(i_sample.volt);
    assign n_asum  = r_asum - SUM_W'(sub.amp) + SUM_W'(i_sample.amp);
    assign n_tasum = r_tasum - SUM_W'(signed'(sub.temp_a)) + SUM_W'(signed'(i_sample.temp_a));
    assign n_tbsum = r_tbsum - SUM_W'(signed'(sub.temp_b)) + SUM_W'(signed'(i_sample.temp_b));

    assign n_filled = r_filled || (i_pos == AW'(WINDOW - 1));

    // Limit checks on the averages, folded into sum thresholds
    assign v_hi = n_vsum > i_thr_volt;
    assign a_hi = n_asum > i_thr_amp;
    assign t_hi = (n_tasum > i_thr_temp) || (n_tbsum > i_thr_temp);

    // Full-charge run count, saturating
    assign qual    = (i_sample.volt > i_full.min_volt) && (i_sample.amp < i_full.max_amp);
    assign cnt_inc = (r_run_cnt != wcam_pkg::RUN_COUNT_MAX) ? r_run_cnt + 16'd1 : r_run_cnt;
    assign full_hit = i_chg && qual && (cnt_inc > i_full.check_limit);

    always_comb begin
        n_run_cnt = r_run_cnt;
        n_bits    = r_bits;
        if (n_filled) begin
            if (i_chg) begin
                n_run_cnt = qual ? cnt_inc : '0;
            end
            n_bits = r_bits | {full_hit, t_hi, a_hi, v_hi};
        end
    end

    assign entered = !r_alerted && n_filled && (n_bits != '0);

    // Result for this item; a halted block reports its held state
    always_comb begin
        if (r_alerted) begin
            o_result.flag_overvoltage = r_bits[0];
            o_result.flag_overcurrent = r_bits[1];
            o_result.flag_overtemp    = r_bits[2];
            o_result.flag_full        = r_bits[3];
            o_result.alert_now        = 1'b0;
            o_result.halted           = 1'b1;
            o_result.window_ready     = r_filled;
        end else begin
            o_result.flag_overvoltage = n_bits[0];
            o_result.flag_overcurrent = n_bits[1];
            o_result.flag_overtemp    = n_bits[2];
            o_result.flag_full        = n_bits[3];
            o_result.alert_now        = entered;
            o_result.halted           = entered;
            o_result.window_ready     = n_filled;
        end
    end

    // State update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vsum    <= '0;
            r_asum    <= '0;
            r_tasum   <= '0;
            r_tbsum   <= '0;
            r_filled  <= 1'b0;
            r_run_cnt <= '0;
            r_bits    <= '0;
            r_alerted <= 1'b0;
        end else if (o_wr) begin
            r_vsum    <= n_vsum;
            r_asum    <= n_asum;
            r_tasum   <= n_tasum;
            r_tbsum   <= n_tbsum;
            r_filled  <= n_filled;
            r_run_cnt <= n_run_cnt;
            r_bits    <= n_bits;
            r_alerted <= entered;
        end
    end

endmodule

`default_nettype wire

### src/windowed_charge_alert_monitor.sv
// Windowed charge alert monitor top; depends on wcam_pkg, wcam_ram, wcam_cfg, wcam_eval.
// An accepted word is held in the update stage register; as it leaves that stage, the sums
// update, it is written back to the ring and its result word goes to the output register.
// Throughput: one word per cycle unless the result stream stalls; ring read at accept.
// Reset (synchronous, active low) clears sums, counters, flags and fill state;
// the ring memory is not cleared, the fill flag keeps unwritten entries unused.
`default_nettype none

module windowed_charge_alert_monitor #(
    parameter int WINDOW = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [wcam_pkg::SAMPLE_W-1:0]     s_axis_tdata,  // volt, amp, temp_a, temp_b
    input  wire logic                              s_axis_tuser,  // charging
    // result stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // flag_overvoltage, flag_overcurrent, flag_overtemp, flag_full,
    // alert_now, halted, window_ready, zero pad
    output logic      [wcam_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // configuration writes
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [wcam_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  wire logic [15:0]                       i_cfg_data
);

    localparam int AW    = $clog2(WINDOW);
    localparam int SUM_W = 16 + $clog2(WINDOW);

    logic                    accept, s1_go, ring_wr;
    logic [AW-1:0]           r_rd_pos;
    logic                    r_s1_valid;
    wcam_pkg::t_sample       r_s1_sample;
    logic                    r_s1_chg;
    logic [AW-1:0]           r_s1_pos;
    wcam_pkg::t_sample       ring_old;
    logic [wcam_pkg::SAMPLE_W-1:0] ring_rdata;
    logic                    r_out_valid;
    wcam_pkg::t_result       r_out;
    wcam_pkg::t_result       result;
    logic [SUM_W-1:0]        thr_volt, thr_amp;
    logic signed [SUM_W-1:0] thr_temp;
    wcam_pkg::t_full_cfg     full_cfg;

    // Handshakes
    assign s1_go         = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_go;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // Ring read pointer, one step per accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pos <= '0;
        end else if (accept) begin
            r_rd_pos <= (r_rd_pos == AW'(WINDOW - 1)) ? '0 : r_rd_pos + AW'(1);
        end
    end

    // Update stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Update stage payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_sample <= s_axis_tdata;
            r_s1_chg    <= s_axis_tuser;
            r_s1_pos    <= r_rd_pos;
        end
    end

    // Ring memory, all four channels in one word
    wcam_ram #(
        .WIDTH (wcam_pkg::SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_wr),
        .i_waddr (r_s1_pos),
        .i_wdata (r_s1_sample),
        .i_re    (accept),
        .i_raddr (r_rd_pos),
        .o_rdata (ring_rdata)
    );

    assign ring_old = ring_rdata;

    wcam_cfg #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (i_cfg_valid),
        .i_idx      (i_cfg_addr),
        .i_data     (i_cfg_data),
        .o_thr_volt (thr_volt),
        .o_thr_amp  (thr_amp),
        .o_thr_temp (thr_temp),
        .o_full     (full_cfg)
    );

    wcam_eval #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W),
        .AW     (AW)
    ) u_eval (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (s1_go),
        .i_sample   (r_s1_sample),
        .i_chg      (r_s1_chg),
        .i_old      (ring_old),
        .i_pos      (r_s1_pos),
        .i_thr_volt (thr_volt),
        .i_thr_amp  (thr_amp),
        .i_thr_temp (thr_temp),
        .i_full     (full_cfg),
        .o_wr       (ring_wr),
        .o_result   (result)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = wcam_pkg::OUT_DATA_W'(r_out);

endmodule

`default_nettype wire
